FILE: rtl/rgb_block_to_ypbpr_420_top_macros.svh
`ifndef RGB_BLOCK_TO_YPBPR_420_TOP_MACROS_SVH
`define RGB_BLOCK_TO_YPBPR_420_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define RBYP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define RBYP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rbyp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rbyp_pkg;

  localparam int COMP_BITS = 8;
  localparam int LUMA_W    = 16;
  localparam int CHROMA_W  = 16;
  localparam int LSUM_W    = 24;  // one pixel's luma sum before rounding
  localparam int CPIX_W    = 25;  // one pixel's signed chroma sum
  localparam int CSUM_W    = 28;  // four pixels' chroma sum plus rounding

  // Q0.16 coefficients; chroma terms are kept as magnitudes and subtracted
  localparam logic [15:0] Y_R   = 16'd19595;
  localparam logic [15:0] Y_G   = 16'd38470;
  localparam logic [15:0] Y_B   = 16'd7471;
  localparam logic [15:0] PB_RM = 16'd11058;
  localparam logic [15:0] PB_GM = 16'd21710;
  localparam logic [15:0] PR_GM = 16'd27439;
  localparam logic [15:0] PR_BM = 16'd5329;
  // weight 32768 on Pb blue and Pr red is a shift by this much
  localparam int HALF_SHIFT = 15;

  typedef logic [COMP_BITS-1:0] comp_t;

  typedef struct packed {
    comp_t r;
    comp_t g;
    comp_t b;
  } rgb_t;

  typedef struct packed {
    comp_t red_top_left;
    comp_t green_top_left;
    comp_t blue_top_left;
    comp_t red_bottom_left;
    comp_t green_bottom_left;
    comp_t blue_bottom_left;
    comp_t red_top_right;
    comp_t green_top_right;
    comp_t blue_top_right;
    comp_t red_bottom_right;
    comp_t green_bottom_right;
    comp_t blue_bottom_right;
  } block_in_t;

  typedef struct packed {
    logic        [LUMA_W-1:0]   luma_top_left;
    logic        [LUMA_W-1:0]   luma_bottom_left;
    logic        [LUMA_W-1:0]   luma_top_right;
    logic        [LUMA_W-1:0]   luma_bottom_right;
    logic signed [CHROMA_W-1:0] blue_difference_avg;
    logic signed [CHROMA_W-1:0] red_difference_avg;
  } block_out_t;

  typedef struct packed {
    logic        [LSUM_W-1:0] luma;
    logic signed [CPIX_W-1:0] pb;
    logic signed [CPIX_W-1:0] pr;
  } pix_sum_t;

endpackage

`default_nettype wire

FILE: rtl/rbyp_pix.sv
`timescale 1ns / 1ps
`default_nettype none

// Two stages for one pixel: constant products, then the per-pixel sums.
module rbyp_pix (
  input  wire logic              clk,
  input  wire rbyp_pkg::rgb_t    pix,
  output rbyp_pkg::pix_sum_t     sums
);
  import rbyp_pkg::*;

  // stage 1 registers
  logic [22:0] yr;
  logic [23:0] yg;
  logic [20:0] yb;
  logic [21:0] pbr;
  logic [22:0] pbg;
  logic [22:0] prg;
  logic [20:0] prb;
  comp_t       r1;
  comp_t       b1;

  always_ff @(posedge clk) begin
    yr  <= 23'(pix.r) * 23'(Y_R);
    yg  <= 24'(pix.g) * 24'(Y_G);
    yb  <= 21'(pix.b) * 21'(Y_B);
    pbr <= 22'(pix.r) * 22'(PB_RM);
    pbg <= 23'(pix.g) * 23'(PB_GM);
    prg <= 23'(pix.g) * 23'(PR_GM);
    prb <= 21'(pix.b) * 21'(PR_BM);
    r1  <= pix.r;
    b1  <= pix.b;
  end

  pix_sum_t sums_next;

  always_comb begin
    sums_next.luma = LSUM_W'(yr) + yg + LSUM_W'(yb);
    sums_next.pb   = $signed({2'b00, b1, {HALF_SHIFT{1'b0}}})
                   - $signed({3'b000, pbr})
                   - $signed({2'b00, pbg});
    sums_next.pr   = $signed({2'b00, r1, {HALF_SHIFT{1'b0}}})
                   - $signed({2'b00, prg})
                   - $signed({4'b0000, prb});
  end

  always_ff @(posedge clk) begin
    sums <= sums_next;
  end

endmodule

`default_nettype wire

FILE: rtl/rbyp_fin.sv
`timescale 1ns / 1ps
`default_nettype none

// Last stage: round the lumas, add the four chroma terms, round and scale.
module rbyp_fin (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  valid,
  input  wire rbyp_pkg::pix_sum_t    tl,
  input  wire rbyp_pkg::pix_sum_t    bl,
  input  wire rbyp_pkg::pix_sum_t    tr,
  input  wire rbyp_pkg::pix_sum_t    br,
  output logic                       strobe,
  output rbyp_pkg::block_out_t       result
);
  import rbyp_pkg::*;

  localparam logic [LSUM_W-1:0]        LUMA_HALF   = LSUM_W'(128);
  localparam logic signed [CSUM_W-1:0] CHROMA_HALF = CSUM_W'(512);

  block_out_t              result_next;
  logic signed [CSUM_W-1:0] pb_sum;
  logic signed [CSUM_W-1:0] pr_sum;
  logic [LSUM_W-1:0]        l_tl, l_bl, l_tr, l_br;

  always_comb begin
    l_tl = tl.luma + LUMA_HALF;
    l_bl = bl.luma + LUMA_HALF;
    l_tr = tr.luma + LUMA_HALF;
    l_br = br.luma + LUMA_HALF;
    pb_sum = CSUM_W'(tl.pb) + CSUM_W'(bl.pb) + CSUM_W'(tr.pb) + CSUM_W'(br.pb)
           + CHROMA_HALF;
    pr_sum = CSUM_W'(tl.pr) + CSUM_W'(bl.pr) + CSUM_W'(tr.pr) + CSUM_W'(br.pr)
           + CHROMA_HALF;
    result_next.luma_top_left       = l_tl[LSUM_W-1:8];
    result_next.luma_bottom_left    = l_bl[LSUM_W-1:8];
    result_next.luma_top_right      = l_tr[LSUM_W-1:8];
    result_next.luma_bottom_right   = l_br[LSUM_W-1:8];
    // floor shift by 10, then keep the low sixteen bits
    result_next.blue_difference_avg = pb_sum[CHROMA_W+9:10];
    result_next.red_difference_avg  = pr_sum[CHROMA_W+9:10];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= valid;
    end
    result <= result_next;
  end

endmodule

`default_nettype wire

FILE: rtl/rgb_block_to_ypbpr_420_top.sv
`timescale 1ns / 1ps
`default_nettype none
// A block taken on start passes v1, v2 and then strobe, which is high with its result.
// Throughput: one 2x2 block per cycle; three register stages (products, pixel sums, final sum).
// busy stays low: the pipeline never stalls and the receiver cannot hold results off.
// Reset clears the valid bits of the pipeline; data registers are not reset.

`include "rgb_block_to_ypbpr_420_top_macros.svh"

module rgb_block_to_ypbpr_420_top (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire rbyp_pkg::block_in_t   pixels,
  output logic                       strobe,
  output rbyp_pkg::block_out_t       result
);
  import rbyp_pkg::*;

  logic     v1;
  logic     v2;
  pix_sum_t s_tl, s_bl, s_tr, s_br;
  rgb_t     p_tl, p_bl, p_tr, p_br;

  assign busy = 1'b0;

  assign p_tl = '{r: pixels.red_top_left,     g: pixels.green_top_left,
                  b: pixels.blue_top_left};
  assign p_bl = '{r: pixels.red_bottom_left,  g: pixels.green_bottom_left,
                  b: pixels.blue_bottom_left};
  assign p_tr = '{r: pixels.red_top_right,    g: pixels.green_top_right,
                  b: pixels.blue_top_right};
  assign p_br = '{r: pixels.red_bottom_right, g: pixels.green_bottom_right,
                  b: pixels.blue_bottom_right};

  // valid bits follow the word through the two pixel stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
    end
  end

  rbyp_pix u_pix_tl (.clk(clk), .pix(p_tl), .sums(s_tl));
  rbyp_pix u_pix_bl (.clk(clk), .pix(p_bl), .sums(s_bl));
  rbyp_pix u_pix_tr (.clk(clk), .pix(p_tr), .sums(s_tr));
  rbyp_pix u_pix_br (.clk(clk), .pix(p_br), .sums(s_br));

  rbyp_fin u_fin (
    .clk    (clk),
    .rst    (rst),
    .valid  (v2),
    .tl     (s_tl),
    .bl     (s_bl),
    .tr     (s_tr),
    .br     (s_br),
    .strobe (strobe),
    .result (result)
  );

  `RBYP_ASSERT_SAME(a_strobe_has_word, clk, rst, strobe, $past(start, 3), "result without a word")
  `RBYP_ASSERT_NEXT(a_v2_gives_strobe, clk, rst, v2, strobe, "word lost in last stage")
  `RBYP_ASSERT_SAME(a_luma_range, clk, rst, strobe,
                    (result.luma_top_left <= 16'd65280) && (result.luma_bottom_right <= 16'd65280),
                    "luma out of range")

endmodule

`default_nettype wire
